### sv/ffha_pkg.sv
`default_nettype none
package ffha_pkg;

   localparam int unsigned DEF_MAX_SEGMENTS = 64;
   localparam int unsigned DEF_PAGE_BYTES = 4096;
   localparam int unsigned DEF_HEADER_BYTES = 32;

   localparam int unsigned GRAIN = 16;
   localparam int unsigned OFFSET_SPACE = 1048576;
   localparam logic [8:0] ARENA_RESET_PAGES = 9'd16;
   localparam int unsigned SEG_COUNT_BITS = 11;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE = 1'b1;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_OOM     = 2'd1,
      ST_IGNORED = 2'd2,
      ST_UNKNOWN = 2'd3
   } status_type;

   typedef struct packed {
      logic        mode;
      logic [20:0] request_bytes;
      logic [19:0] release_offset;
   } req_type;

   typedef struct packed {
      logic [19:0] payload_offset;
      status_type  status;
   } rsp_type;

   typedef struct packed {
      logic [19:0] start;
      logic [20:0] length;
      logic        is_free;
   } entry_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_CHK,
      S_SCAN,
      S_ADEC,
      S_OPEN,
      S_WA,
      S_WB,
      S_NB1,
      S_NB2,
      S_NB3,
      S_MRG,
      S_CLOSE,
      S_RESP
   } state_type;

   typedef struct packed {
      logic       init;
      logic       load_req;
      logic       scan;
      logic       open_go;
      logic       open_run;
      logic       write_a;
      logic       write_b;
      logic       nb_next;
      logic       nb_prev;
      logic       nb_cap;
      logic       merge;
      logic       close_run;
      logic       rsp_load;
      status_type rsp_code;
   } cmd_type;

   typedef struct packed {
      logic                      ignore;
      logic                      is_free_op;
      logic                      hit;
      logic                      miss;
      logic                      split;
      logic                      open_done;
      logic                      close_done;
      logic [SEG_COUNT_BITS-1:0] seg_count;
   } stat_type;

endpackage
`default_nettype wire

### sv/ffha_datapath.sv
`default_nettype none
module ffha_datapath #(
   parameter int unsigned MAX_SEGMENTS = ffha_pkg::DEF_MAX_SEGMENTS,
   parameter int unsigned PAGE_BYTES = ffha_pkg::DEF_PAGE_BYTES,
   parameter int unsigned HEADER_BYTES = ffha_pkg::DEF_HEADER_BYTES
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [8:0]        csr_wdata,
   input  wire ffha_pkg::req_type req_data,
   input  wire ffha_pkg::cmd_type cmd,
   output ffha_pkg::stat_type     stat,
   output ffha_pkg::rsp_type      rsp_data
);
   import ffha_pkg::*;

   localparam int unsigned IW = $clog2(MAX_SEGMENTS);
   localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
   localparam int unsigned MOST_PAGES = (OFFSET_SPACE / PAGE_BYTES < 1) ? 1 :
                                        OFFSET_SPACE / PAGE_BYTES;
   localparam logic [22:0] HDR = 23'(HEADER_BYTES);
   localparam logic [22:0] SPLIT_MIN = 23'(HEADER_BYTES + GRAIN);
   localparam logic [21:0] GRAIN_MASK = 22'(GRAIN - 1);
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_SEGMENTS);

   entry_type tbl_mem [MAX_SEGMENTS];

   logic [8:0]    arena_ff;
   logic [CW-1:0] count_ff;
   req_type       req_ff;
   logic [CW-1:0] ptr_ff;
   logic          rpend_ff;
   logic [CW-1:0] ridx_ff;
   entry_type     rdata_ff;
   logic [IW-1:0] hit_ff;
   entry_type     cur_ff;
   entry_type     nxt_ff;
   entry_type     prv_ff;
   logic [1:0]    del_ff;
   rsp_type       rsp_ff;

   logic [31:0]   pages_cl;
   logic [31:0]   init_len;
   logic [21:0]   need;
   logic          match;
   logic          scan_hit;
   logic [22:0]   rest;
   logic          split;
   logic [CW-1:0] hit_ext;
   logic          has_next;
   logic          has_prev;
   logic          rd_en;
   logic [IW-1:0] raddr;
   logic          wen;
   logic [IW-1:0] waddr;
   entry_type     wdata;

   always_comb begin
      pages_cl = 32'(arena_ff);
      if (pages_cl < 32'd1) begin
         pages_cl = 32'd1;
      end
      if (pages_cl > 32'(MOST_PAGES)) begin
         pages_cl = 32'(MOST_PAGES);
      end
   end

   assign init_len = pages_cl * 32'(PAGE_BYTES);
   assign need = ({1'b0, req_ff.request_bytes} + GRAIN_MASK) & ~GRAIN_MASK;
   assign hit_ext = CW'(hit_ff);
   assign has_next = (hit_ext + CW'(1)) < count_ff;
   assign has_prev = (hit_ff != '0);

   // Allocate looks for room; free looks for the segment whose payload starts at the offset.
   always_comb begin
      if (req_ff.mode == MODE_ALLOC) begin
         match = rdata_ff.is_free && ({2'b00, rdata_ff.length} >= HDR + {1'b0, need});
      end else begin
         match = ({1'b0, rdata_ff.start} + HDR[20:0]) == {1'b0, req_ff.release_offset};
      end
   end

   assign scan_hit = cmd.scan && rpend_ff && match;
   assign rest = {2'b00, cur_ff.length} - HDR - {1'b0, need};
   assign split = (rest >= SPLIT_MIN) && (count_ff < MAX_COUNT);

   always_comb begin
      rd_en = 1'b0;
      raddr = ptr_ff[IW-1:0];
      wen = 1'b0;
      waddr = hit_ff;
      wdata = cur_ff;
      if (cmd.init) begin
         wen = 1'b1;
         waddr = '0;
         wdata.start = '0;
         wdata.length = init_len[20:0];
         wdata.is_free = 1'b1;
      end
      if (cmd.scan) begin
         rd_en = (ptr_ff < count_ff) && !scan_hit;
      end
      if (cmd.open_run) begin
         rd_en = ptr_ff > hit_ext;
         wen = rpend_ff;
         waddr = IW'(ridx_ff + CW'(1));
         wdata = rdata_ff;
      end
      if (cmd.close_run) begin
         rd_en = ptr_ff < count_ff;
         wen = rpend_ff;
         waddr = IW'(ridx_ff - CW'(del_ff));
         wdata = rdata_ff;
      end
      if (cmd.write_a) begin
         wen = 1'b1;
         waddr = hit_ff;
         wdata.start = cur_ff.start;
         wdata.length = split ? 21'(HDR + {1'b0, need}) : cur_ff.length;
         wdata.is_free = 1'b0;
      end
      if (cmd.write_b) begin
         wen = 1'b1;
         waddr = IW'(hit_ext + CW'(1));
         wdata.start = 20'(HDR + {1'b0, need} + {3'b000, cur_ff.start});
         wdata.length = rest[20:0];
         wdata.is_free = 1'b1;
      end
      if (cmd.nb_next) begin
         raddr = IW'(hit_ext + CW'(1));
      end
      if (cmd.nb_prev) begin
         raddr = IW'(hit_ff - IW'(1));
      end
      if (cmd.merge) begin
         wen = 1'b1;
         if (prv_ff.is_free) begin
            waddr = IW'(hit_ff - IW'(1));
            wdata.start = prv_ff.start;
            wdata.length = prv_ff.length + cur_ff.length +
                           (nxt_ff.is_free ? nxt_ff.length : 21'd0);
         end else begin
            waddr = hit_ff;
            wdata.start = cur_ff.start;
            wdata.length = cur_ff.length + (nxt_ff.is_free ? nxt_ff.length : 21'd0);
         end
         wdata.is_free = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wen) begin
         tbl_mem[waddr] <= wdata;
      end
      rdata_ff <= tbl_mem[raddr];
      ridx_ff <= CW'(raddr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         arena_ff <= ARENA_RESET_PAGES;
         count_ff <= CW'(1);
         rpend_ff <= 1'b0;
      end else begin
         rpend_ff <= rd_en;
         if (csr_we) begin
            arena_ff <= csr_wdata;
         end
         if (cmd.init) begin
            count_ff <= CW'(1);
         end
         if (cmd.write_b) begin
            count_ff <= count_ff + CW'(1);
         end
         if (cmd.close_run && !rpend_ff && ptr_ff >= count_ff) begin
            count_ff <= count_ff - CW'(del_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
         ptr_ff <= '0;
      end
      if (rd_en && (cmd.scan || cmd.close_run)) begin
         ptr_ff <= ptr_ff + CW'(1);
      end
      if (rd_en && cmd.open_run) begin
         ptr_ff <= ptr_ff - CW'(1);
      end
      if (cmd.open_go) begin
         ptr_ff <= count_ff - CW'(1);
      end
      if (scan_hit) begin
         hit_ff <= ridx_ff[IW-1:0];
         cur_ff <= rdata_ff;
      end
      if (cmd.nb_prev) begin
         nxt_ff <= '{start: rdata_ff.start, length: rdata_ff.length,
                     is_free: rdata_ff.is_free && has_next};
      end
      if (cmd.nb_cap) begin
         prv_ff <= '{start: rdata_ff.start, length: rdata_ff.length,
                     is_free: rdata_ff.is_free && has_prev};
      end
      if (cmd.merge) begin
         // The close sweep pulls later entries down over the merged ones.
         if (prv_ff.is_free) begin
            del_ff <= nxt_ff.is_free ? 2'd2 : 2'd1;
            ptr_ff <= hit_ext + (nxt_ff.is_free ? CW'(2) : CW'(1));
         end else if (nxt_ff.is_free) begin
            del_ff <= 2'd1;
            ptr_ff <= hit_ext + CW'(2);
         end else begin
            del_ff <= 2'd0;
            ptr_ff <= count_ff;
         end
      end
      if (cmd.rsp_load) begin
         rsp_ff.status <= cmd.rsp_code;
         if (cmd.rsp_code == ST_OK && req_ff.mode == MODE_ALLOC) begin
            rsp_ff.payload_offset <= cur_ff.start + HDR[19:0];
         end else begin
            rsp_ff.payload_offset <= '0;
         end
      end
   end

   always_comb begin
      stat.ignore = (req_ff.mode == MODE_ALLOC) ? (req_ff.request_bytes == '0) :
                                                  (req_ff.release_offset == '0);
      stat.is_free_op = (req_ff.mode == MODE_FREE);
      stat.hit = scan_hit;
      stat.miss = !rpend_ff && (ptr_ff >= count_ff);
      stat.split = split;
      stat.open_done = !rpend_ff && (ptr_ff <= hit_ext);
      stat.close_done = !rpend_ff && (ptr_ff >= count_ff);
      stat.seg_count = SEG_COUNT_BITS'(count_ff);
   end

   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

### sv/ffha_controller.sv
`default_nettype none
module ffha_controller (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   input  wire logic               csr_we,
   input  wire ffha_pkg::stat_type stat,
   output ffha_pkg::cmd_type       cmd
);
   import ffha_pkg::*;

   state_type  state_ff;
   state_type  state_in;
   status_type code_ff;
   status_type code_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         code_ff <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         code_ff <= code_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      code_in = code_ff;
      cmd = '0;
      cmd.rsp_code = code_ff;
      req_stall = 1'b1;
      case (state_ff)
         S_INIT: begin
            cmd.init = 1'b1;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (stat.ignore) begin
               code_in = ST_IGNORED;
               state_in = S_RESP;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.hit) begin
               state_in = stat.is_free_op ? S_NB1 : S_ADEC;
            end else if (stat.miss) begin
               code_in = stat.is_free_op ? ST_UNKNOWN : ST_OOM;
               state_in = S_RESP;
            end
         end
         S_ADEC: begin
            if (stat.split) begin
               cmd.open_go = 1'b1;
               state_in = S_OPEN;
            end else begin
               state_in = S_WA;
            end
         end
         S_OPEN: begin
            cmd.open_run = 1'b1;
            if (stat.open_done) begin
               state_in = S_WA;
            end
         end
         S_WA: begin
            cmd.write_a = 1'b1;
            if (stat.split) begin
               state_in = S_WB;
            end else begin
               code_in = ST_OK;
               state_in = S_RESP;
            end
         end
         S_WB: begin
            cmd.write_b = 1'b1;
            code_in = ST_OK;
            state_in = S_RESP;
         end
         S_NB1: begin
            cmd.nb_next = 1'b1;
            state_in = S_NB2;
         end
         S_NB2: begin
            cmd.nb_prev = 1'b1;
            state_in = S_NB3;
         end
         S_NB3: begin
            cmd.nb_cap = 1'b1;
            state_in = S_MRG;
         end
         S_MRG: begin
            cmd.merge = 1'b1;
            state_in = S_CLOSE;
         end
         S_CLOSE: begin
            cmd.close_run = 1'b1;
            if (stat.close_done) begin
               code_in = ST_OK;
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
      // A new arena size restarts the heap.
      if (csr_we) begin
         state_in = S_INIT;
      end
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

### sv/first_fit_heap_allocator_unit.sv
// First-fit heap allocator over an arena of whole pages.
// Requests arrive on the req_ channel (valid/stall); each request beat carries a mode
// (allocate or free), a byte count and a release offset. Every request gives exactly
// one response beat on the rsp_ channel with a payload offset and a status.
// One request is processed at a time. An allocate runs a check, a first-fit scan of the
// table, the opening of a table slot when it splits, and then writes the table and
// loads the response. A free runs the check, a lookup scan, the neighbor merge, a sweep
// that closes the table, and then loads the response.
// The segment table sets the pace: one entry is read and one written per cycle.
// Zero-size or null requests skip the scan and go from the check state to the response.
// The response sits in an output register; the next request is taken while it waits.
// When rsp_stall is high the response beat holds and the block stops after finishing
// the following request until the response is taken.
// Reset sets the arena to 16 pages and builds the single free segment in the init
// state. A write on csr_we sets the arena size in pages and restarts the heap the
// same way; the user must do this only while idle: the block does not enforce it.
`default_nettype none
module first_fit_heap_allocator_unit #(
   parameter int unsigned MAX_SEGMENTS = ffha_pkg::DEF_MAX_SEGMENTS,
   parameter int unsigned PAGE_BYTES = ffha_pkg::DEF_PAGE_BYTES,
   parameter int unsigned HEADER_BYTES = ffha_pkg::DEF_HEADER_BYTES
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire ffha_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output ffha_pkg::rsp_type      rsp_data,
   input  wire logic              csr_we,
   input  wire logic [8:0]        csr_wdata
);
   import ffha_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   ffha_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_we    (csr_we),
      .stat      (stat),
      .cmd       (cmd)
   );

   ffha_datapath #(
      .MAX_SEGMENTS (MAX_SEGMENTS),
      .PAGE_BYTES   (PAGE_BYTES),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !csr_we) |=> req_stall)
      else $error("request taken while the previous one is still in work");

   a_offset_only_on_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |-> (rsp_data.payload_offset == '0))
      else $error("nonzero offset on a failed or ignored request");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (stat.seg_count != '0) &&
      (stat.seg_count <= SEG_COUNT_BITS'(MAX_SEGMENTS)))
      else $error("segment count out of range");

   a_one_cmd_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.init, cmd.write_a, cmd.write_b, cmd.merge}))
      else $error("two table writes commanded at once");
`endif

endmodule
`default_nettype wire

### dv/tb_top.sv
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ffha_pkg::*;

   localparam int unsigned NSEG = DEF_MAX_SEGMENTS;
   localparam int unsigned HDR = DEF_HEADER_BYTES;
   localparam int unsigned PAGE = DEF_PAGE_BYTES;

   // Mirror of the allocator: segment table plus pending responses.
   class heap_scoreboard;
      int unsigned seg_start[NSEG];
      int unsigned seg_len[NSEG];
      bit seg_free[NSEG];
      int unsigned seg_count;
      rsp_type pending[$];
      int unsigned errors;

      function void restart(logic [8:0] pages);
         int unsigned p;
         p = pages;
         if (p < 1) p = 1;
         if (p > OFFSET_SPACE / PAGE) p = OFFSET_SPACE / PAGE;
         seg_start[0] = 0;
         seg_len[0] = p * PAGE;
         seg_free[0] = 1'b1;
         seg_count = 1;
      endfunction

      function void remove_at(int unsigned i);
         for (int unsigned k = i; k + 1 < seg_count; k++) begin
            seg_start[k] = seg_start[k + 1];
            seg_len[k] = seg_len[k + 1];
            seg_free[k] = seg_free[k + 1];
         end
         seg_count--;
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         longint unsigned need, room, rest;
         int unsigned i;
         e.payload_offset = '0;
         e.status = ST_OOM;
         if (r.mode == MODE_ALLOC) begin
            if (r.request_bytes == 0) e.status = ST_IGNORED;
            else begin
               need = (longint'(r.request_bytes) + 15) & ~longint'(15);
               for (i = 0; i < seg_count; i++) begin
                  if (!seg_free[i]) continue;
                  room = seg_len[i] - HDR;
                  if (room >= need) begin
                     rest = room - need;
                     if (rest >= HDR + GRAIN && seg_count < NSEG) begin
                        for (int unsigned k = seg_count; k > i + 1; k--) begin
                           seg_start[k] = seg_start[k - 1];
                           seg_len[k] = seg_len[k - 1];
                           seg_free[k] = seg_free[k - 1];
                        end
                        seg_count++;
                        seg_start[i + 1] = 32'(seg_start[i] + HDR + need);
                        seg_len[i + 1] = 32'(rest);
                        seg_free[i + 1] = 1'b1;
                        seg_len[i] = 32'(HDR + need);
                     end
                     seg_free[i] = 1'b0;
                     e.payload_offset = 20'(seg_start[i] + HDR);
                     e.status = ST_OK;
                     break;
                  end
               end
            end
         end else if (r.release_offset == 0) e.status = ST_IGNORED;
         else begin
            for (i = 0; i < seg_count; i++)
               if (seg_start[i] + HDR == r.release_offset) break;
            if (i >= seg_count) e.status = ST_UNKNOWN;
            else begin
               e.status = ST_OK;
               seg_free[i] = 1'b1;
               if (i + 1 < seg_count && seg_free[i + 1]) begin
                  seg_len[i] += seg_len[i + 1];
                  remove_at(i + 1);
               end
               if (i > 0 && seg_free[i - 1]) begin
                  seg_len[i - 1] += seg_len[i];
                  remove_at(i);
               end
            end
         end
         pending.push_back(e);
      endfunction

      function void check_response(rsp_type a);
         rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: response with none expected: off=%h st=%0d",
                     $time, a.payload_offset, a.status);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.payload_offset !== e.payload_offset) begin
            $display("%0t: payload_offset expected %h actual %h", $time,
                     e.payload_offset, a.payload_offset);
            errors++;
         end
         if (a.status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [8:0] csr_wdata = '0;

   heap_scoreboard heap = new();
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned live_offsets[$];

   first_fit_heap_allocator_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            heap.check_response(rsp_data);
            if (rsp_data.status == ST_OK && rsp_data.payload_offset != 0)
               live_offsets.push_back(32'(rsp_data.payload_offset));
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Valid stays up after an accepted beat so that back-to-back beats need no gap;
   // callers that pause the stream drop it themselves.
   task automatic send_request(req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      heap.note_request(r);
   endtask

   task automatic alloc(int unsigned bytes);
      req_type r;
      r = '0;
      r.mode = MODE_ALLOC;
      r.request_bytes = 21'(bytes);
      r.release_offset = 20'($urandom);
      send_request(r);
   endtask

   task automatic release_at(int unsigned off);
      req_type r;
      r = '0;
      r.mode = MODE_FREE;
      r.release_offset = 20'(off);
      r.request_bytes = 21'($urandom);
      send_request(r);
   endtask

   task automatic drain_then_config(logic [8:0] pages);
      req_valid <= 1'b0;
      while (heap.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= pages;
      @(posedge clock);
      csr_we <= 1'b0;
      heap.restart(pages);
      live_offsets.delete();
      repeat (3) @(posedge clock);
   endtask

   task automatic random_phase(int unsigned n);
      int unsigned pick, idx;
      for (int unsigned k = 0; k < n; k++) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            if ($urandom_range(9) == 0) alloc($urandom_range(1048576, 0));
            else if ($urandom_range(3) == 0) alloc($urandom_range(4096, 1));
            else alloc($urandom_range(256, 1));
         end else if (pick < 85 && live_offsets.size() != 0) begin
            idx = $urandom_range(live_offsets.size() - 1);
            release_at(live_offsets[idx]);
            live_offsets.delete(idx);
         end else if (pick < 90) alloc(0);
         else if (pick < 93) release_at(0);
         else if (pick < 97) release_at($urandom_range(1048575, 1));
         else release_at(32);
      end
   endtask

   initial begin
      heap.restart(ARENA_RESET_PAGES);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: extremes of size, special statuses, then exhaustion and merges.
      alloc(0);
      release_at(0);
      release_at(20'hFFFFF);
      alloc(1);
      alloc(16);
      alloc(17);
      release_at(32);
      release_at(32);
      release_at(80);
      alloc(21'h1FFFFF);
      alloc(1048576);
      alloc(65536 - 32);
      alloc(100);
      release_at(96);
      release_at(144);
      alloc(48);
      release_at(12345);
      drain_then_config(9'd0);
      alloc(4096 - 32);
      alloc(1);
      drain_then_config(9'h1FF);
      alloc(1048576 - 32);
      release_at(32);
      drain_then_config(9'd256);
      // Fill the table so the no-split path is exercised.
      for (int unsigned k = 0; k < 70; k++) alloc(16);
      drain_then_config(9'd1);
      for (int unsigned k = 0; k < 80; k++) alloc(16);
      for (int unsigned k = 0; k < 60; k++) release_at(32 + 48 * k);

      drain_then_config(9'd16);
      random_phase(250);
      send_idle_pct = 88;
      drain_then_config(9'd4);
      random_phase(200);
      send_idle_pct = 0;
      stall_pct = 88;
      drain_then_config(9'd256);
      random_phase(200);
      send_idle_pct = 15;
      stall_pct = 15;
      drain_then_config(9'd2);
      random_phase(200);
      send_idle_pct = 0;
      stall_pct = 0;
      drain_then_config(9'd64);
      random_phase(100);

      req_valid <= 1'b0;
      stall_pct = 0;
      while (heap.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (heap.errors == 0 && heap.pending.size() == 0) $display("tb_top: PASS");
      else $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      #30ms;
      $display("tb_top: FAIL");
      $finish;
   end
endmodule
`default_nettype wire

### first_fit_heap_allocator_unit.f
sv/ffha_pkg.sv
sv/ffha_datapath.sv
sv/ffha_controller.sv
sv/first_fit_heap_allocator_unit.sv
dv/tb_top.sv
